[design/sim_pkg.sv]
// Shared types, constants and register codes of the seismic intensity meter.
`default_nettype none

package sim_pkg;

	localparam int OFFSET_LEN_DEF = 64;
	localparam int WINDOW_DEF     = 128;

	localparam int RAW_W   = 16;
	localparam int ZC_W    = 15;
	localparam int GAIN_W  = 16;
	localparam int SMW_W   = 17;
	localparam int BIAS_W  = 11;
	localparam int ACC_W   = 18;
	localparam int INT_W   = 12;
	localparam int PW      = 36;
	localparam int E_W     = 6;
	localparam int MANT_W  = 31;
	localparam int FRAC_W  = 16;
	localparam int L2_W    = 1 + E_W + FRAC_W;
	localparam int LM_W    = L2_W + 16;
	localparam int LOG_SHIFT = 24;

	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 17;
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 72;
	localparam int OUT_PAD_W  = OUT_DATA_W - 3 * ACC_W - INT_W;

	localparam logic [ZC_W-1:0]   ZERO_CODE_RST = ZC_W'(13200);
	localparam logic [GAIN_W-1:0] GAIN_RST      = GAIN_W'(12172);
	localparam logic [SMW_W-1:0]  SMOOTH_RST    = SMW_W'(6554);
	localparam logic [BIAS_W-1:0] BIAS_RST      = BIAS_W'(241);
	localparam logic [SMW_W-1:0]  SMOOTH_ONE    = SMW_W'(65536);

	// log10(2) in Q16 scaled so that the product shifts right by 24
	localparam logic signed [15:0]     LOG_SCALE  = 16'sd19728;
	localparam logic signed [L2_W-1:0] GAL2_OFFS  = L2_W'(8 * 65536);
	localparam logic signed [INT_W-1:0] INT_MIN   = -12'sd2048;
	localparam logic signed [INT_W-1:0] INT_MAX   = 12'sd2047;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_ZERO_CODE = 2'd0,
		REG_GAIN      = 2'd1,
		REG_SMOOTH    = 2'd2,
		REG_BIAS      = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic load_in;
		logic conv;
		logic acc;
		logic total;
		logic div_load;
		logic div_step;
		logic mean;
		logic smul;
		logic smooth;
		logic square;
		logic psum;
		logic wwr;
		logic sort_wr;
		logic sort_wr_new;
		logic cap_sel;
		logic bank_flip;
		logic log_load;
		logic norm_shift;
		logic log_mant;
		logic log_iter;
		logic log_mul;
		logic log_out;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic x_eq_old;
		logic new_ge_x;
		logic norm_done;
		logic sel_zero;
	} status_t;

endpackage

`default_nettype wire

[design/sim_datapath.sv]
// Datapath: conversion, mean removal, smoothing, power window, sorted window and log unit.
`default_nettype none

module sim_datapath
	import sim_pkg::*;
#(
	parameter int OFFSET_LEN = OFFSET_LEN_DEF,
	parameter int WINDOW = WINDOW_DEF,
	localparam int WIN_AW = $clog2(WINDOW)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic [IN_DATA_W-1:0]  in_data,
	input  wire cmd_t                  cmd,
	input  wire logic [WIN_AW-1:0]     sort_rd_addr,
	input  wire logic [WIN_AW-1:0]     sort_wr_addr,
	output status_t                    st,
	output logic [OUT_DATA_W-1:0]      out_data
);

	localparam int OFF_AW = $clog2(OFFSET_LEN);
	localparam int TOT_W  = ACC_W + OFF_AW;
	localparam int UW     = TOT_W + 1;
	localparam int D_W    = ACC_W + 2;
	localparam int SAT_W  = 24;
	// reciprocal of OFFSET_LEN, exact for every UW-bit dividend
	localparam int RK     = UW + OFF_AW;
	localparam longint RECIP = ((longint'(1) <<< RK) + longint'(OFFSET_LEN) - longint'(1))
		/ longint'(OFFSET_LEN);
	localparam logic [UW:0] RECIP_M = (UW + 1)'(RECIP);

	function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SAT_W-1:0] v);
		logic signed [SAT_W-1:0] hi;
		logic signed [SAT_W-1:0] lo;
		hi = SAT_W'(131071);
		lo = -SAT_W'(131072);
		if (v > hi) begin
			return ACC_W'(hi);
		end else if (v < lo) begin
			return ACC_W'(lo);
		end
		return ACC_W'(v);
	endfunction

	// configuration
	logic [ZC_W-1:0]   zero_code_q;
	logic [GAIN_W-1:0] gain_q;
	logic [SMW_W-1:0]  smooth_w_q;
	logic [BIAS_W-1:0] bias_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_code_q <= ZERO_CODE_RST;
			gain_q      <= GAIN_RST;
			smooth_w_q  <= SMOOTH_RST;
			bias_q      <= BIAS_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_addr))
				REG_ZERO_CODE: zero_code_q <= cfg_data[ZC_W-1:0];
				REG_GAIN:      gain_q      <= cfg_data[GAIN_W-1:0];
				REG_SMOOTH:    smooth_w_q  <= cfg_data;
				REG_BIAS:      bias_q      <= cfg_data[BIAS_W-1:0];
				default:       ;
			endcase
		end
	end

	logic [SMW_W-1:0] w_eff;
	logic [SMW_W-1:0] w_rest;
	assign w_eff  = (smooth_w_q > SMOOTH_ONE) ? SMOOTH_ONE : smooth_w_q;
	assign w_rest = SMOOTH_ONE - w_eff;

	// per-axis lanes
	logic signed [RAW_W-1:0]   raw_q   [3];
	logic signed [33:0]        conv_q  [3];
	logic signed [ACC_W-1:0]   acc_q   [3];
	logic signed [TOT_W-1:0]   total_q [3];
	logic [UW-1:0]             u_q     [3];
	logic                      neg_q   [3];
	logic signed [D_W-1:0]     d_q     [3];
	logic signed [35:0]        ps_q    [3];
	logic signed [37:0]        pd_q    [3];
	logic signed [ACC_W-1:0]   s_q     [3];
	logic [34:0]               sq_q    [3];
	logic signed [ACC_W-1:0]   old_v   [3];

	// mean ring: entries not yet written read as zero until the first wrap
	logic [3*ACC_W-1:0]  ring_mem [OFFSET_LEN];
	logic [3*ACC_W-1:0]  ring_rd_q;
	logic [OFF_AW-1:0]   ring_ptr_q;
	logic                wrapped_q;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			ring_rd_q <= ring_mem[ring_ptr_q];
		end
		if (cmd.total) begin
			ring_mem[ring_ptr_q] <= {acc_q[2], acc_q[1], acc_q[0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_ptr_q <= '0;
			wrapped_q  <= 1'b0;
		end else if (cmd.total) begin
			if (ring_ptr_q == OFF_AW'(OFFSET_LEN - 1)) begin
				ring_ptr_q <= '0;
				wrapped_q  <= 1'b1;
			end else begin
				ring_ptr_q <= ring_ptr_q + 1'b1;
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			old_v[k] = wrapped_q ? $signed(ring_rd_q[k*ACC_W +: ACC_W]) : '0;
		end
	end

	// lane arithmetic
	logic signed [16:0]      diff_v  [3];
	logic [2*UW:0]           qm_v    [3];
	logic signed [UW-1:0]    tx_v    [3];
	logic [UW-1:0]           q_v     [3];
	logic signed [D_W-1:0]   mean_v  [3];
	logic signed [38:0]      sum_v   [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			diff_v[k]  = 17'(raw_q[k]) - $signed({2'b00, zero_code_q});
			qm_v[k]    = (2 * UW + 1)'(u_q[k]) * (2 * UW + 1)'(RECIP_M);
			tx_v[k]    = UW'(total_q[k]);
			q_v[k]     = neg_q[k] ? (~u_q[k] + 1'b1) : u_q[k];
			mean_v[k]  = $signed(q_v[k][D_W-1:0]);
			sum_v[k]   = 39'(ps_q[k]) + 39'(pd_q[k]);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			if (cmd.load_in) begin
				raw_q[k] <= $signed(in_data[k*RAW_W +: RAW_W]);
			end
			if (cmd.conv) begin
				conv_q[k] <= diff_v[k] * $signed({1'b0, gain_q});
			end
			if (cmd.acc) begin
				acc_q[k] <= sat_acc(SAT_W'(conv_q[k] >>> 12));
			end
			if (cmd.div_load) begin
				neg_q[k] <= total_q[k][TOT_W-1];
				u_q[k]   <= total_q[k][TOT_W-1]
					? UW'(-tx_v[k] + UW'(OFFSET_LEN - 1)) : UW'(tx_v[k]);
			end else if (cmd.div_step) begin
				u_q[k]   <= UW'(qm_v[k] >> RK);
			end
			if (cmd.mean) begin
				d_q[k] <= D_W'(acc_q[k]) - mean_v[k];
			end
			if (cmd.smul) begin
				ps_q[k] <= s_q[k] * $signed({1'b0, w_rest});
				pd_q[k] <= d_q[k] * $signed({1'b0, w_eff});
			end
			if (cmd.square) begin
				sq_q[k] <= 35'(s_q[k] * s_q[k]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				total_q[k] <= '0;
				s_q[k]     <= '0;
			end
		end else begin
			for (int k = 0; k < 3; k++) begin
				if (cmd.total) begin
					total_q[k] <= total_q[k] + TOT_W'(acc_q[k]) - TOT_W'(old_v[k]);
				end
				if (cmd.smooth) begin
					s_q[k] <= sat_acc(SAT_W'(sum_v[k] >>> 16));
				end
			end
		end
	end

	// power and window ring in arrival order
	logic [PW-1:0]     p_q;
	logic [PW-1:0]     win_mem [WINDOW];
	logic [PW-1:0]     win_rd_q;
	logic [WIN_AW-1:0] win_ptr_q;

	always_ff @(posedge clk) begin
		if (cmd.psum) begin
			p_q <= PW'(sq_q[0]) + PW'(sq_q[1]) + PW'(sq_q[2]);
		end
		if (cmd.load_in) begin
			win_rd_q <= win_mem[win_ptr_q];
		end
		if (cmd.wwr) begin
			win_mem[win_ptr_q] <= p_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_ptr_q <= '0;
		end else if (cmd.wwr) begin
			win_ptr_q <= (win_ptr_q == WIN_AW'(WINDOW - 1)) ? '0 : win_ptr_q + 1'b1;
		end
	end

	// sorted window, two banks: merge from one into the other
	logic [PW-1:0]   sort_mem [2 * (2 ** WIN_AW)];
	logic [PW-1:0]   sort_rd_q;
	logic [PW-1:0]   sort_wr_v;
	logic [PW-1:0]   sel_q;
	logic            bank_q;

	assign sort_wr_v = cmd.sort_wr_new ? p_q : sort_rd_q;

	always_ff @(posedge clk) begin
		sort_rd_q <= sort_mem[{bank_q, sort_rd_addr}];
		if (cmd.sort_wr) begin
			sort_mem[{~bank_q, sort_wr_addr}] <= sort_wr_v;
		end
		if (cmd.cap_sel) begin
			sel_q <= sort_wr_v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q <= 1'b0;
		end else if (cmd.bank_flip) begin
			bank_q <= ~bank_q;
		end
	end

	// log2 unit: normalise, then square the mantissa once per fraction bit
	logic [PW-1:0]              norm_q;
	logic [E_W-1:0]             e_q;
	logic [MANT_W-1:0]          m_q;
	logic [FRAC_W-1:0]          frac_q;
	logic signed [LM_W-1:0]     lm_q;
	logic signed [INT_W-1:0]    int_q;
	logic [2*MANT_W-1:0]        mm_v;
	logic [MANT_W:0]            t_v;
	logic signed [L2_W-1:0]     l2_v;
	logic signed [LM_W-LOG_SHIFT:0] iv_v;

	assign mm_v = m_q * m_q;
	assign t_v  = mm_v[2*MANT_W-1:MANT_W-1];
	assign l2_v = $signed({1'b0, e_q, frac_q}) - GAL2_OFFS;
	assign iv_v = (LM_W - LOG_SHIFT + 1)'(lm_q >>> LOG_SHIFT)
		+ (LM_W - LOG_SHIFT + 1)'($signed(bias_q));

	always_ff @(posedge clk) begin
		if (cmd.log_load) begin
			norm_q <= sel_q;
			e_q    <= E_W'(PW - 1);
		end else if (cmd.norm_shift) begin
			norm_q <= {norm_q[PW-2:0], 1'b0};
			e_q    <= e_q - 1'b1;
		end
		if (cmd.log_mant) begin
			m_q    <= norm_q[PW-1 -: MANT_W];
			frac_q <= '0;
		end else if (cmd.log_iter) begin
			if (t_v[MANT_W]) begin
				m_q    <= t_v[MANT_W:1];
				frac_q <= {frac_q[FRAC_W-2:0], 1'b1};
			end else begin
				m_q    <= t_v[MANT_W-1:0];
				frac_q <= {frac_q[FRAC_W-2:0], 1'b0};
			end
		end
		if (cmd.log_mul) begin
			lm_q <= l2_v * LOG_SCALE;
		end
		if (cmd.log_out) begin
			if (sel_q == '0) begin
				int_q <= INT_MIN;
			end else if (iv_v > (LM_W - LOG_SHIFT + 1)'(INT_MAX)) begin
				int_q <= INT_MAX;
			end else if (iv_v < (LM_W - LOG_SHIFT + 1)'(INT_MIN)) begin
				int_q <= INT_MIN;
			end else begin
				int_q <= INT_W'(iv_v);
			end
		end
		if (cmd.load_out) begin
			out_data <= {{OUT_PAD_W{1'b0}}, int_q, s_q[2], s_q[1], s_q[0]};
		end
	end

	assign st.x_eq_old  = (sort_rd_q == win_rd_q);
	assign st.new_ge_x  = (p_q >= sort_rd_q);
	assign st.norm_done = norm_q[PW-1];
	assign st.sel_zero  = (sel_q == '0);

endmodule

`default_nettype wire

[design/sim_ctrl.sv]
// Controller: sequences one sample through the datapath and runs the sorted-window merge.
`default_nettype none

module sim_ctrl
	import sim_pkg::*;
#(
	parameter int WINDOW = WINDOW_DEF,
	localparam int WIN_AW = $clog2(WINDOW)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire status_t           st,
	output cmd_t                   cmd,
	output logic [WIN_AW-1:0]      sort_rd_addr,
	output logic [WIN_AW-1:0]      sort_wr_addr
);

	localparam int IC_W      = $clog2(FRAC_W);
	localparam int CNT_W     = WIN_AW + 1;

	typedef enum logic [4:0] {
		ST_IDLE, ST_CONV, ST_ACC, ST_TOTAL, ST_DIVLD, ST_DIV, ST_MEAN, ST_SMUL,
		ST_SMOOTH, ST_SQUARE, ST_PSUM, ST_WWR, ST_SORT_RD, ST_SORT_STEP,
		ST_LOG_LD, ST_NORM, ST_MANT, ST_ITER, ST_LMUL, ST_LOUT, ST_EMIT
	} state_t;

	state_t            state_q;
	logic [IC_W-1:0]   iter_cnt_q;
	logic [CNT_W-1:0]  fill_q;
	logic [WIN_AW-1:0] rank_q;
	logic [3:0]        resid_q;
	logic [CNT_W-1:0]  n_q;
	logic              evict_q;
	logic [CNT_W-1:0]  rd_i_q;
	logic [CNT_W-1:0]  wr_j_q;
	logic              ins_q;
	logic              del_q;
	logic              out_valid_q;

	logic i_end, done, skip, put_new, put_x, emit;

	assign i_end   = (rd_i_q == n_q);
	assign done    = i_end && ins_q;
	assign skip    = !i_end && evict_q && !del_q && st.x_eq_old;
	assign put_new = !done && !skip && !ins_q && (i_end || st.new_ge_x);
	assign put_x   = !done && !skip && !put_new;
	assign emit    = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	assign in_ready     = (state_q == ST_IDLE);
	assign out_valid    = out_valid_q;
	assign sort_rd_addr = rd_i_q[WIN_AW-1:0];
	assign sort_wr_addr = wr_j_q[WIN_AW-1:0];

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE:      cmd.load_in  = in_valid;
			ST_CONV:      cmd.conv     = 1'b1;
			ST_ACC:       cmd.acc      = 1'b1;
			ST_TOTAL:     cmd.total    = 1'b1;
			ST_DIVLD:     cmd.div_load = 1'b1;
			ST_DIV:       cmd.div_step = 1'b1;
			ST_MEAN:      cmd.mean     = 1'b1;
			ST_SMUL:      cmd.smul     = 1'b1;
			ST_SMOOTH:    cmd.smooth   = 1'b1;
			ST_SQUARE:    cmd.square   = 1'b1;
			ST_PSUM:      cmd.psum     = 1'b1;
			ST_WWR:       cmd.wwr      = 1'b1;
			ST_SORT_RD:   ;
			ST_SORT_STEP: begin
				cmd.sort_wr     = put_new || put_x;
				cmd.sort_wr_new = put_new;
				cmd.cap_sel     = (put_new || put_x) && (wr_j_q == CNT_W'(rank_q));
				cmd.bank_flip   = done;
			end
			ST_LOG_LD:    cmd.log_load   = 1'b1;
			ST_NORM:      cmd.norm_shift = !st.norm_done;
			ST_MANT:      cmd.log_mant   = 1'b1;
			ST_ITER:      cmd.log_iter   = 1'b1;
			ST_LMUL:      cmd.log_mul    = 1'b1;
			ST_LOUT:      cmd.log_out    = 1'b1;
			ST_EMIT:      cmd.load_out   = emit;
			default:      ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			iter_cnt_q  <= '0;
			fill_q      <= '0;
			rank_q      <= '0;
			resid_q     <= '0;
			n_q         <= '0;
			evict_q     <= 1'b0;
			rd_i_q      <= '0;
			wr_j_q      <= '0;
			ins_q       <= 1'b0;
			del_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE:   if (in_valid) state_q <= ST_CONV;
				ST_CONV:   state_q <= ST_ACC;
				ST_ACC:    state_q <= ST_TOTAL;
				ST_TOTAL:  state_q <= ST_DIVLD;
				ST_DIVLD:  state_q <= ST_DIV;
				ST_DIV:    state_q <= ST_MEAN;
				ST_MEAN:   state_q <= ST_SMUL;
				ST_SMUL:   state_q <= ST_SMOOTH;
				ST_SMOOTH: state_q <= ST_SQUARE;
				ST_SQUARE: state_q <= ST_PSUM;
				ST_PSUM:   state_q <= ST_WWR;
				ST_WWR: begin
					// old fill sizes the merge; new fill sets the rank
					n_q     <= fill_q;
					evict_q <= (fill_q == CNT_W'(WINDOW));
					if (fill_q != CNT_W'(WINDOW)) begin
						fill_q <= fill_q + 1'b1;
						if (resid_q >= 4'd7) begin
							resid_q <= resid_q - 4'd7;
							rank_q  <= rank_q + 1'b1;
						end else begin
							resid_q <= resid_q + 4'd3;
						end
					end
					rd_i_q  <= '0;
					wr_j_q  <= '0;
					ins_q   <= 1'b0;
					del_q   <= 1'b0;
					state_q <= ST_SORT_RD;
				end
				ST_SORT_RD: state_q <= ST_SORT_STEP;
				ST_SORT_STEP: begin
					priority if (done) begin
						state_q <= ST_LOG_LD;
					end else if (skip) begin
						del_q   <= 1'b1;
						rd_i_q  <= rd_i_q + 1'b1;
						state_q <= ST_SORT_RD;
					end else if (put_new) begin
						ins_q  <= 1'b1;
						wr_j_q <= wr_j_q + 1'b1;
					end else begin
						rd_i_q  <= rd_i_q + 1'b1;
						wr_j_q  <= wr_j_q + 1'b1;
						state_q <= ST_SORT_RD;
					end
				end
				ST_LOG_LD: state_q <= st.sel_zero ? ST_LOUT : ST_NORM;
				ST_NORM:   if (st.norm_done) state_q <= ST_MANT;
				ST_MANT: begin
					iter_cnt_q <= '0;
					state_q    <= ST_ITER;
				end
				ST_ITER: begin
					iter_cnt_q <= iter_cnt_q + 1'b1;
					if (iter_cnt_q == IC_W'(FRAC_W - 1)) state_q <= ST_LMUL;
				end
				ST_LMUL:   state_q <= ST_LOUT;
				ST_LOUT:   state_q <= ST_EMIT;
				ST_EMIT: begin
					if (emit) begin
						state_q <= ST_IDLE;
					end
				end
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

[design/seismic_intensity_meter.sv]
// Seismic intensity meter top level: stream ports, configuration port, controller and datapath.
//
// Usage: one three-axis ADC sample per input transaction on s_*, one result per sample on m_*.
// Configuration registers (zero code, gain, smoothing weight, intensity bias) are written
// through cfg_we/cfg_addr/cfg_data while no sample is in flight.
// Throughput: one sample at a time. The time from acceptance to the output register grows
// with the number of samples held in the window before it and with the normalise count; a
// zero selected magnitude skips the log unit. The sorted-window merge, which walks the window
// through one memory read port, takes the largest share once the window is full.
// The next sample is taken as soon as the result is in the output register, so a stalled
// receiver holds only the finished result; a further result waits for m_tready.
// Reset makes the mean ring read as zero until it is first refilled, clears the sums,
// the smoothing state and the window count, and loads the register defaults.
`default_nettype none

module seismic_intensity_meter
	import sim_pkg::*;
#(
	parameter int OFFSET_LEN = OFFSET_LEN_DEF,
	parameter int WINDOW = WINDOW_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,   // raw_x, raw_y, raw_z
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,   // smooth_x, smooth_y, smooth_z, intensity_q8
	input  wire logic                  cfg_we,
	input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int WIN_AW = $clog2(WINDOW);

	cmd_t              cmd;
	status_t           st;
	logic [WIN_AW-1:0] sort_rd_addr;
	logic [WIN_AW-1:0] sort_wr_addr;

	sim_ctrl #(
		.WINDOW(WINDOW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.st(st),
		.cmd(cmd),
		.sort_rd_addr(sort_rd_addr),
		.sort_wr_addr(sort_wr_addr)
	);

	sim_datapath #(
		.OFFSET_LEN(OFFSET_LEN),
		.WINDOW(WINDOW)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_data(cfg_data),
		.in_data(s_tdata),
		.cmd(cmd),
		.sort_rd_addr(sort_rd_addr),
		.sort_wr_addr(sort_wr_addr),
		.st(st),
		.out_data(m_tdata)
	);

endmodule

`default_nettype wire
